>>> design/rsq_pkg.sv
package rsq_pkg;

   localparam int ROWS_DEFAULT = 16;
   localparam int COLS_DEFAULT = 64;

   // Cell tags.
   localparam logic [1:0] TAG_EMPTY = 2'd0;
   localparam logic [1:0] TAG_END   = 2'd1;
   localparam logic [1:0] TAG_FULL  = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Request commands.
   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;   // write one reset word of the cell memory
      logic accept;  // latch the request and issue the cell read
      logic exec;    // finish the operation and load the result register
      logic spill;   // write the value into column 0 of the new row
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // the clearing pass is at its last cell
      logic slot_free;   // the result register can take a result
      logic spill;       // the finishing enqueue opens a new row
   } dp_status_type;

endpackage

>>> design/rsq_dpath.sv
module rsq_dpath #(
   parameter int ROWS = rsq_pkg::ROWS_DEFAULT,
   parameter int COLS = rsq_pkg::COLS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsq_pkg::ctl_cmd_type  ctl,
   output rsq_pkg::dp_status_type sts,
   input  logic                  req_cmd,
   input  logic signed [31:0]    req_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic signed [31:0]    rsp_data
);

   localparam int NCELLS = ROWS * COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int AW1    = AW + 1;
   localparam int RW     = $clog2(ROWS + 1);
   localparam int PW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS + 1);
   localparam int KW     = $clog2(COLS);

   // Each word holds the tag above the data.
   logic [33:0] mem [NCELLS];
   logic [33:0] rd_ff;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [33:0]       wr_data;
   logic              rd_en;

   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [KW-1:0]     clr_col_ff, clr_col_in;
   logic [RW-1:0]     prow_ff, prow_in;
   logic [CW-1:0]     pcol_ff, pcol_in;
   logic [PW-1:0]     pub_ff, pub_in;
   logic [CW-1:0]     head_ff, head_in;
   logic              cmd_ff, cmd_in;
   logic signed [31:0] value_ff, value_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_data_ff, rsp_data_in;

   logic [AW:0]       enq_sum;
   logic [AW:0]       deq_sum;
   logic [AW:0]       spill_sum;
   logic              enq_hit;
   logic              deq_hit;
   logic [RW-1:0]     prow_next;
   logic              is_full;
   logic              old_end;
   logic              last_row;
   logic [1:0]        rd_tag;

   assign enq_sum   = AW1'(prow_ff) * AW1'(COLS) + AW1'(pcol_ff);
   assign deq_sum   = AW1'(pub_ff) * AW1'(COLS) + AW1'(head_ff);
   assign spill_sum = AW1'(prow_ff) * AW1'(COLS);
   assign enq_hit   = (prow_ff < RW'(ROWS)) && (pcol_ff < CW'(COLS));
   assign deq_hit   = head_ff < CW'(COLS);
   assign prow_next = prow_ff + RW'(1);
   assign is_full   = prow_ff >= RW'(ROWS);
   assign rd_tag    = rd_ff[33:32];
   assign old_end   = !hit_ff || (rd_tag == rsq_pkg::TAG_END);
   assign last_row  = prow_ff == RW'(ROWS - 1);

   assign sts.clear_last = clr_addr_ff == AW'(NCELLS - 1);
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;
   assign sts.spill      = (cmd_ff == rsq_pkg::CMD_ENQ) && !is_full && old_end && !last_row;

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      clr_col_in    = clr_col_ff;
      prow_in       = prow_ff;
      pcol_in       = pcol_ff;
      pub_in        = pub_ff;
      head_in       = head_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      hit_in        = hit_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {rsq_pkg::TAG_FULL, value_ff};
      rd_en         = 1'b0;

      if (ctl.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = {(clr_col_ff == KW'(COLS - 1)) ? rsq_pkg::TAG_END : rsq_pkg::TAG_EMPTY,
                    32'd0};
         clr_addr_in = clr_addr_ff + AW'(1);
         clr_col_in  = (clr_col_ff == KW'(COLS - 1)) ? '0 : clr_col_ff + KW'(1);
      end

      if (ctl.accept) begin
         cmd_in   = req_cmd;
         value_in = req_value;
         if (req_cmd == rsq_pkg::CMD_ENQ) begin
            hit_in  = enq_hit;
            addr_in = enq_sum[AW-1:0];
         end else begin
            hit_in  = deq_hit;
            addr_in = deq_sum[AW-1:0];
         end
         rd_en = hit_in;
      end

      if (ctl.exec) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = rsq_pkg::ST_OK;
         if (cmd_ff == rsq_pkg::CMD_ENQ) begin
            if (is_full) begin
               rsp_status_in = rsq_pkg::ST_FULL;
            end else begin
               wr_en   = hit_ff;
               wr_data = {rsq_pkg::TAG_FULL, value_ff};
               if (!old_end) begin
                  pcol_in = pcol_ff + CW'(1);
               end else if (last_row) begin
                  prow_in       = prow_next;
                  rsp_status_in = rsq_pkg::ST_FULL;
               end else begin
                  prow_in = prow_next;
                  pub_in  = PW'(prow_next);
                  pcol_in = CW'(1);
                  head_in = '0;
               end
            end
         end else begin
            if (!hit_ff) begin
               rsp_status_in = rsq_pkg::ST_EMPTY;
            end else begin
               wr_en   = 1'b1;
               wr_data = {rsq_pkg::TAG_END, rd_ff[31:0]};
               head_in = head_ff + CW'(1);
               if (rd_tag == rsq_pkg::TAG_FULL) begin
                  rsp_data_in = $signed(rd_ff[31:0]);
               end else begin
                  rsp_status_in = rsq_pkg::ST_EMPTY;
               end
            end
         end
      end

      if (ctl.spill) begin
         wr_en   = 1'b1;
         wr_addr = spill_sum[AW-1:0];
         wr_data = {rsq_pkg::TAG_FULL, value_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         clr_col_ff   <= '0;
         prow_ff      <= '0;
         pcol_ff      <= '0;
         pub_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         clr_col_ff   <= clr_col_in;
         prow_ff      <= prow_in;
         pcol_ff      <= pcol_in;
         pub_ff       <= pub_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      hit_ff        <= hit_in;
      addr_ff       <= addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_prow_range: assert property (@(posedge clock) disable iff (reset)
      prow_ff <= RW'(ROWS) && pcol_ff <= CW'(COLS) && head_ff <= CW'(COLS))
      else $error("producer position or head out of range");

   a_pub_moves_on_exec: assert property (@(posedge clock) disable iff (reset)
      !$stable(pub_ff) |-> $past(ctl.exec))
      else $error("published row changed outside an enqueue");

   a_rsp_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != rsq_pkg::ST_OK |-> rsp_data_ff == 32'sd0)
      else $error("nonzero data on a result that is not ok");
`endif

endmodule

>>> design/rsq_ctrl.sv
module rsq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rsq_pkg::dp_status_type sts,
   output rsq_pkg::ctl_cmd_type   ctl
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SPILL
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   assign ctl.clear  = state_ff == S_CLEAR;
   assign ctl.accept = req_valid && req_ready_ff;
   assign ctl.exec   = (state_ff == S_EXEC) && sts.slot_free;
   assign ctl.spill  = state_ff == S_SPILL;
   assign req_ready  = req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (sts.clear_last) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (sts.slot_free) begin
                  if (sts.spill) begin
                     state_ff <= S_SPILL;
                  end else begin
                     state_ff     <= S_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end
            end
            S_SPILL: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
            end
            default: begin
               state_ff     <= S_CLEAR;
               req_ready_ff <= 1'b0;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_spill_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPILL |-> $past(state_ff == S_EXEC && sts.slot_free))
      else $error("row spill without a finishing enqueue");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> state_ff == S_EXEC && !req_ready_ff)
      else $error("accepted request did not move to execution");
`endif

endmodule

>>> design/row_segmented_spmc_queue.sv
// Row-segmented queue with one producer and many consumers, kept in a
// ROWS x COLS grid of cells in a single-port memory. An enqueue (cmd 0)
// fills the producer's row left to right; when it meets a cell that a
// consumer has already stamped with the end tag, the producer moves to the
// next row, stores its value in column 0 there and publishes that row. Past
// the last row every enqueue answers full. A dequeue (cmd 1) takes the cell
// at the head of the published row, stamps it with the end tag, and returns
// its data with status ok if the cell held data, or status empty otherwise.
// Every request gives exactly one result. Each request is a read-modify-write
// of one memory cell: a transfer on the request side issues the read, and the
// execution state that follows writes the cell back and loads the result
// register once that register is free. An enqueue that opens a new row needs
// a second write to the single memory port, in a spill state. A result waiting
// in the result register does not block the next request transfer; a request
// only waits in execution when the result register is still occupied. After
// reset the block walks once through all ROWS*COLS cells (1024 with the default
// sizes), one cell per cycle, to set up the cell tags while req_ready is low.

module row_segmented_spmc_queue #(
   parameter int ROWS = rsq_pkg::ROWS_DEFAULT,
   parameter int COLS = rsq_pkg::COLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data
);

   // Command and status bundles between the sequencer and the datapath.
   rsq_pkg::ctl_cmd_type   ctl;
   rsq_pkg::dp_status_type sts;

   // The controller sequences clearing, accept, write-back and row spill.
   rsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // The datapath holds the cell memory, producer and consumer positions,
   // and the result register.
   rsq_dpath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data)
   );

endmodule

>>> dv/row_segmented_spmc_queue_tb.sv
module row_segmented_spmc_queue_tb;

   localparam int ROWS = rsq_pkg::ROWS_DEFAULT;
   localparam int COLS = rsq_pkg::COLS_DEFAULT;

   // Widths of the copied producer and consumer positions.
   localparam int PUB_W  = $clog2(ROWS);
   localparam int ROW_W  = $clog2(ROWS) + 1;
   localparam int COL_W  = $clog2(COLS);
   localparam int HEAD_W = $clog2(COLS) + 1;

   // The directed part comes first, and the random part fills up to about 1950 requests.
   localparam int DIR_LEN    = 18;
   localparam int RAND_ITEMS = 1932;

   // The slowest correct run is about 1950 requests, some with a row spill.
   // Sender gaps and receiver stalls add to that, and so does the clearing
   // pass over all ROWS*COLS cells after reset. The limit is many times that total.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // The block loads its answer into the result register in the execution state
   // after a request transfer, when that register is free. This margin lets a
   // stray late transfer show up before the run ends.
   localparam int DRAIN_CYCLES = 12;

   // One reply as the block presents it.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
   } reply_type;

   // One row of the directed part. The reply is typed in by hand only where
   // the row is marked fixed. Every other row takes its reply from the predictor.
   typedef struct packed {
      logic               cmd;
      logic signed [31:0] value;
      logic               fixed;
      reply_type          reply;
   } dir_row_type;

   // These are the receiver's stall styles. It stays ready, or it flips a coin
   // each cycle, or it holds ready low.
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BLOCKED} rx_style_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd   = rsq_pkg::CMD_ENQ;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;

   row_segmented_spmc_queue #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_status(rsp_status),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The testbench keeps its own copy of the queue state. This is the grid of
   // tags and words, one head per row, the published row, and the producer's position.
   logic [1:0]          grid_tag  [ROWS*COLS];
   logic signed [31:0]  grid_data [ROWS*COLS];
   logic [HEAD_W-1:0]   grid_head [ROWS];
   logic [PUB_W-1:0]    pub_row;
   logic [ROW_W-1:0]    prod_row;
   logic [COL_W-1:0]    prod_col;

   // These are the replies still owed by the block, oldest first.
   reply_type   owed_replies[$];
   int          fail_count  = 0;
   int unsigned cycle_count = 0;
   int          burst_left  = 0;

   rx_style_type rx_style = RX_OPEN;
   int           rx_left  = 0;

   // The directed part starts from reset. A consumer first stamps the end tag
   // on cell (0,0). That forces the first enqueue to open row 1. The block must
   // then give back the word extremes in order. Two dequeues run past the
   // producer and get empty, and the next enqueue opens row 2. The fixed rows
   // are the ones whose reply is plain from the sequence alone.
   dir_row_type dir_tab [DIR_LEN] = '{
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b1, '{rsq_pkg::ST_EMPTY, 32'h0000_0000}},
      '{rsq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 1'b1, '{rsq_pkg::ST_OK,    32'h0000_0000}},
      '{rsq_pkg::CMD_DEQ, 32'hFFFF_FFFF, 1'b1, '{rsq_pkg::ST_OK,    32'h7FFF_FFFF}},
      '{rsq_pkg::CMD_ENQ, 32'h8000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_ENQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h5A5A_5A5A, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'hA5A5_A5A5, 1'b1, '{rsq_pkg::ST_EMPTY, 32'h0000_0000}},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b1, '{rsq_pkg::ST_EMPTY, 32'h0000_0000}},
      '{rsq_pkg::CMD_ENQ, 32'h1234_5678, 1'b0, '0},
      '{rsq_pkg::CMD_ENQ, 32'h5555_5555, 1'b0, '0},
      '{rsq_pkg::CMD_ENQ, 32'hAAAA_AAAA, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b0, '0},
      '{rsq_pkg::CMD_DEQ, 32'h0000_0000, 1'b1, '{rsq_pkg::ST_EMPTY, 32'h0000_0000}}
   };

   // This applies one request to the copied state and returns the reply it earns.
   function automatic reply_type grid_step(logic cmd, logic signed [31:0] value);
      reply_type  rep;
      int         slot;
      logic [1:0] old_tag;
      rep = '{rsq_pkg::ST_OK, 32'h0000_0000};
      if (cmd == rsq_pkg::CMD_ENQ) begin
         // Once the producer has run off the last row, it stays full.
         if (int'(prod_row) >= ROWS) begin
            rep.status = rsq_pkg::ST_FULL;
            return rep;
         end
         if (int'(prod_col) < COLS) begin
            slot            = int'(prod_row) * COLS + int'(prod_col);
            old_tag         = grid_tag[slot];
            grid_tag[slot]  = rsq_pkg::TAG_FULL;
            grid_data[slot] = value;
         end else begin
            old_tag = rsq_pkg::TAG_END;
         end
         if (old_tag != rsq_pkg::TAG_END) begin
            prod_col = prod_col + COL_W'(1);
         end else begin
            // A consumer got here first. The value moves to column 0 of the
            // next row, and that row is published.
            prod_row = prod_row + ROW_W'(1);
            if (int'(prod_row) >= ROWS) begin
               prod_row   = ROW_W'(ROWS);
               rep.status = rsq_pkg::ST_FULL;
            end else begin
               slot            = int'(prod_row) * COLS;
               grid_tag[slot]  = rsq_pkg::TAG_FULL;
               grid_data[slot] = value;
               pub_row         = prod_row[PUB_W-1:0];
               prod_col        = COL_W'(1);
            end
         end
      end else begin
         // When the head is past the row, the reply is empty and nothing changes.
         if (int'(grid_head[pub_row]) >= COLS) begin
            rep.status = rsq_pkg::ST_EMPTY;
            return rep;
         end
         slot               = int'(pub_row) * COLS + int'(grid_head[pub_row]);
         grid_head[pub_row] = grid_head[pub_row] + HEAD_W'(1);
         old_tag            = grid_tag[slot];
         grid_tag[slot]     = rsq_pkg::TAG_END;
         if (old_tag == rsq_pkg::TAG_FULL)
            rep.data = grid_data[slot];
         else
            rep.status = rsq_pkg::ST_EMPTY;
      end
      return rep;
   endfunction

   // This picks the next command of the random part. The run aims to reach the
   // row limit at about 85 percent of the random part, so that the sticky-full
   // replies and the saturated head both get plenty of traffic. The producer
   // runs ahead of that schedule when dequeues dominate, because consumers then
   // overtake it and stamp end tags. When it is ahead, the mix holds it in its
   // row by keeping a little data in front of the consumers. One pick in
   // twenty is plain noise.
   function automatic logic pick_cmd(int done);
      int target_row;
      int ahead;
      target_row = (done * ROWS * 20) / (RAND_ITEMS * 17);
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(0, 1) ? rsq_pkg::CMD_DEQ : rsq_pkg::CMD_ENQ;
      if (int'(prod_row) < target_row)
         return ($urandom_range(0, 99) < 35) ? rsq_pkg::CMD_ENQ : rsq_pkg::CMD_DEQ;
      ahead = int'(prod_col) - int'(grid_head[pub_row]);
      if (ahead <= 2)
         return rsq_pkg::CMD_ENQ;
      if (int'(prod_col) >= COLS - 2)
         return rsq_pkg::CMD_DEQ;
      return $urandom_range(0, 1) ? rsq_pkg::CMD_DEQ : rsq_pkg::CMD_ENQ;
   endfunction

   // The sender works in bursts. Between bursts, valid drops for a gap before it
   // rises again, so that valid is never lowered and raised in the same step.
   task automatic send_request(logic cmd, logic signed [31:0] value, logic fixed,
                               reply_type fixed_reply);
      int        gap;
      reply_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left = burst_left - 1;
      req_cmd   <= cmd;
      req_value <= value;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      // The transfer happened at this edge. The predictor must still see every
      // request, fixed rows included, to keep its state in step.
      predicted = grid_step(cmd, value);
      owed_replies.push_back(fixed ? fixed_reply : predicted);
   endtask

   // This is the receiver's stall pattern. It runs in phases of random length and style.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style = rx_style_type'($urandom_range(0, 2));
         rx_left  = (rx_style == RX_BLOCKED) ? $urandom_range(1, 6) : $urandom_range(4, 30);
      end else begin
         rx_left = rx_left - 1;
      end
      case (rx_style)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= 1'b0;
      endcase
   end

   // Every reply transfer is checked against the oldest reply still owed.
   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            $error("reply with none owed: status %0d data 0x%08h", rsp_status, rsp_data);
            fail_count++;
         end else begin
            want = owed_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected 0x%08h, actual 0x%08h", want.data, rsp_data);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("row_segmented_spmc_queue: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic               cmd;
      logic signed [31:0] value;
      // The copied state starts as reset leaves the block. Every cell is empty,
      // except the last cell of each row, which holds the end tag.
      for (int i = 0; i < ROWS * COLS; i++) begin
         grid_tag[i]  = ((i % COLS) == COLS - 1) ? rsq_pkg::TAG_END : rsq_pkg::TAG_EMPTY;
         grid_data[i] = '0;
      end
      for (int r = 0; r < ROWS; r++)
         grid_head[r] = '0;
      pub_row  = '0;
      prod_row = '0;
      prod_col = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_LEN; i++)
         send_request(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].fixed, dir_tab[i].reply);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         cmd = pick_cmd(n);
         case ($urandom_range(0, 7))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            default: value = $urandom();
         endcase
         send_request(cmd, value, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("row_segmented_spmc_queue: match");
      else
         $display("row_segmented_spmc_queue: mismatch");
      $finish;
   end

endmodule
